// ===== src/gis_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Gripper intake sequencer package
// Shared types and constants for the sequencer datapath and its channels.
// ----------------------------------------------------------------------------
package gis_pkg;

  localparam int TIMER_BITS  = 16;
  localparam int WINDOW_BITS = 16;
  localparam int CMP_BITS    = (TIMER_BITS > WINDOW_BITS) ? TIMER_BITS : WINDOW_BITS;
  localparam int CFG_IDX_BITS = 1;

  localparam logic [CFG_IDX_BITS-1:0] CFG_SHORT_WINDOW = CFG_IDX_BITS'(0);
  localparam logic [CFG_IDX_BITS-1:0] CFG_LONG_WINDOW  = CFG_IDX_BITS'(1);

  localparam logic [WINDOW_BITS-1:0] SHORT_WINDOW_RESET = WINDOW_BITS'(25);
  localparam logic [WINDOW_BITS-1:0] LONG_WINDOW_RESET  = WINDOW_BITS'(50);

  localparam logic [TIMER_BITS-1:0] TIMER_MAX = {TIMER_BITS{1'b1}};

  typedef enum logic [2:0] {
    MODE_STOWED   = 3'd0,
    MODE_INTAKING = 3'd1,
    MODE_IWAIT    = 3'd2,
    MODE_ISTOP    = 3'd3,
    MODE_EJECT    = 3'd4,
    MODE_OVWAIT   = 3'd5
  } mode_t;

  typedef enum logic [1:0] {
    SPIN_STOP = 2'd0,
    SPIN_IN   = 2'd1,
    SPIN_OUT  = 2'd2
  } spin_t;

  typedef struct packed {
    logic intake_press;
    logic eject_press;
    logic stow_press;
    logic ignore_press;
    logic left_switch_level;
    logic right_switch_level;
  } tick_item_t;

  typedef struct packed {
    mode_t                 mode_next;
    logic [TIMER_BITS-1:0] elapsed_next;
    logic                  running_next;
    spin_t                 spin;
  } step_t;

endpackage
`default_nettype wire

// ===== src/gis_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Gripper intake sequencer channels
// Valid/ready channels for button ticks and for sequencer results.
// ----------------------------------------------------------------------------
interface gis_tick_if;
  logic valid;
  logic ready;
  logic intake_press;
  logic eject_press;
  logic stow_press;
  logic ignore_press;
  logic left_switch_level;
  logic right_switch_level;

  modport source (
    output valid, intake_press, eject_press, stow_press, ignore_press,
           left_switch_level, right_switch_level,
    input  ready
  );
  modport sink (
    input  valid, intake_press, eject_press, stow_press, ignore_press,
           left_switch_level, right_switch_level,
    output ready
  );
endinterface

interface gis_result_if import gis_pkg::*; ();
  logic  valid;
  logic  ready;
  mode_t mode_now;
  spin_t spin_command;

  modport source (output valid, mode_now, spin_command, input ready);
  modport sink (input valid, mode_now, spin_command, output ready);
endinterface
`default_nettype wire

// ===== src/gripper_intake_sequencer_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Gripper intake sequencer unit
// Six-state gripper sequencer with a tick timer, one result per input tick.
// ----------------------------------------------------------------------------
// Each tick transferred on the tick channel produces exactly one result
// (new mode and spin command) on the result channel. A tick is registered,
// evaluated together with the sequencer state from the input register, and
// the result lands in an output register. One tick can be taken every cycle
// while the result channel is not stalled; a stalled result holds the flow.
// A waiting result lets the tick channel accept only while the input register
// is empty or can drain into the result register. Window registers are
// written through cfg_we/cfg_index/cfg_data and should only change while idle.
module gripper_intake_sequencer_unit import gis_pkg::*; (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    cfg_we,
  input  wire logic [CFG_IDX_BITS-1:0] cfg_index,
  input  wire logic [WINDOW_BITS-1:0]  cfg_data,
  gis_tick_if.sink                     tick,
  gis_result_if.source                 result
);

  logic [WINDOW_BITS-1:0] short_window_ticks;
  logic [WINDOW_BITS-1:0] long_window_ticks;
  mode_t                  mode;
  logic [TIMER_BITS-1:0]  elapsed;
  logic                   running;
  logic                   in_valid;
  tick_item_t             in_item;
  logic                   out_valid;
  mode_t                  out_mode;
  spin_t                  out_spin;
  logic                   advance;
  step_t                  step;

  assign advance      = in_valid && (!out_valid || result.ready);
  assign tick.ready   = !in_valid || advance;

  assign result.valid        = out_valid;
  assign result.mode_now     = out_mode;
  assign result.spin_command = out_spin;

  always_ff @(posedge clk) begin
    if (rst) begin
      short_window_ticks <= SHORT_WINDOW_RESET;
      long_window_ticks  <= LONG_WINDOW_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SHORT_WINDOW: short_window_ticks <= cfg_data;
        CFG_LONG_WINDOW:  long_window_ticks  <= cfg_data;
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (tick.ready) begin
      in_valid <= tick.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (tick.valid && tick.ready) begin
      in_item <= '{intake_press:       tick.intake_press,
                   eject_press:        tick.eject_press,
                   stow_press:         tick.stow_press,
                   ignore_press:       tick.ignore_press,
                   left_switch_level:  tick.left_switch_level,
                   right_switch_level: tick.right_switch_level};
    end
  end

  gis_step u_step (
    .mode               (mode),
    .elapsed            (elapsed),
    .running            (running),
    .short_window_ticks (short_window_ticks),
    .long_window_ticks  (long_window_ticks),
    .item               (in_item),
    .step               (step)
  );

  // sequencer state moves on each tick that reaches the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      mode    <= MODE_STOWED;
      elapsed <= '0;
      running <= 1'b0;
    end else if (advance) begin
      mode    <= step.mode_next;
      elapsed <= step.elapsed_next;
      running <= step.running_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_mode <= step.mode_next;
      out_spin <= step.spin;
    end
  end

endmodule
`default_nettype wire

// ===== src/gis_step.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Gripper intake sequencer step logic
// Timer advance, window compares and the six-state transition for one tick.
// ----------------------------------------------------------------------------
module gis_step import gis_pkg::*; (
  input  wire mode_t                  mode,
  input  wire logic [TIMER_BITS-1:0]  elapsed,
  input  wire logic                   running,
  input  wire logic [WINDOW_BITS-1:0] short_window_ticks,
  input  wire logic [WINDOW_BITS-1:0] long_window_ticks,
  input  wire tick_item_t             item,
  output step_t                       step
);

  logic [TIMER_BITS-1:0] t_now;
  logic [CMP_BITS-1:0]   t_cmp;
  logic [CMP_BITS-1:0]   short_cmp;
  logic [CMP_BITS-1:0]   long_cmp;
  logic                  past_short;
  logic                  below_long;
  logic                  past_long;
  logic                  present;
  mode_t                 mode_eff;

  // running timer counts first, saturating
  assign t_now = (running && (elapsed != TIMER_MAX)) ? elapsed + TIMER_BITS'(1) : elapsed;

  assign t_cmp      = CMP_BITS'(t_now);
  assign short_cmp  = CMP_BITS'(short_window_ticks);
  assign long_cmp   = CMP_BITS'(long_window_ticks);
  assign past_short = t_cmp > short_cmp;
  assign below_long = t_cmp < long_cmp;
  assign past_long  = t_cmp > long_cmp;

  // switches are active low
  assign present  = !item.left_switch_level || !item.right_switch_level;
  assign mode_eff = item.stow_press ? MODE_STOWED : mode;

  always_comb begin
    step.mode_next    = mode_eff;
    step.elapsed_next = t_now;
    step.running_next = running;
    step.spin         = SPIN_STOP;
    case (mode_eff)
      MODE_INTAKING: begin
        step.spin = SPIN_IN;
        if (item.eject_press) begin
          step.elapsed_next = '0;
          step.running_next = 1'b1;
          step.mode_next    = MODE_OVWAIT;
        end else if (present && !item.ignore_press) begin
          step.elapsed_next = '0;
          step.running_next = 1'b1;
          step.mode_next    = MODE_IWAIT;
        end
      end
      MODE_IWAIT: begin
        step.spin = SPIN_IN;
        if (past_short && below_long && present) begin
          step.running_next = 1'b0;
          step.spin         = SPIN_STOP;
          step.mode_next    = MODE_ISTOP;
        end else if (past_long) begin
          step.running_next = 1'b0;
          step.mode_next    = MODE_INTAKING;
        end
      end
      MODE_ISTOP: begin
        if (item.eject_press) begin
          step.spin         = SPIN_OUT;
          step.elapsed_next = '0;
          step.running_next = 1'b1;
          step.mode_next    = MODE_EJECT;
        end else if (item.intake_press) begin
          step.spin      = SPIN_IN;
          step.mode_next = MODE_INTAKING;
        end
      end
      MODE_EJECT: begin
        step.spin = SPIN_OUT;
        if (past_short) begin
          step.spin         = SPIN_STOP;
          step.running_next = 1'b0;
          step.mode_next    = MODE_STOWED;
        end
      end
      MODE_OVWAIT: begin
        step.spin = SPIN_IN;
        if (past_short) begin
          step.spin         = SPIN_STOP;
          step.running_next = 1'b0;
          step.mode_next    = MODE_ISTOP;
        end
      end
      default: begin
        // stowed, and any unused code behaves as stowed
        step.mode_next = MODE_STOWED;
        if (item.intake_press) begin
          step.spin      = SPIN_IN;
          step.mode_next = MODE_INTAKING;
        end else if (item.eject_press) begin
          step.elapsed_next = '0;
          step.running_next = 1'b1;
          step.spin         = SPIN_OUT;
          step.mode_next    = MODE_EJECT;
        end
      end
    endcase
  end

endmodule
`default_nettype wire
